FILE: rtl/core/scp_pkg.sv
// Package for the sine/cosine polynomial core: formats, constants, coefficient table
// and the data record handed along the Horner cell chain. No dependencies.
`default_nettype none
package scp_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_IN    = 28;
    localparam int DOWN_SH    = (DATA_WIDTH > 32) ? DATA_WIDTH - 32 : 0;
    localparam int UP_SH      = (DATA_WIDTH < 32) ? 32 - DATA_WIDTH : 0;
    localparam int EXT_W      = 64;

    localparam int A_W   = 32;
    localparam int XW    = 34;
    localparam int XR_W  = 31;
    localparam int X2_W  = 32;
    localparam int P_W   = 50;
    localparam int PLO   = 24;
    localparam int R_W   = 35;
    localparam int CL_W  = 32;
    localparam int OUT_SH = 46;

    localparam logic signed [XW-1:0] HALF_PI_Q = 34'sd421657428;
    localparam logic signed [XW-1:0] PI_Q      = 34'sd843314857;
    localparam logic signed [XW-1:0] TWO_PI_Q  = 34'sd1686629713;
    localparam logic signed [R_W-1:0] ONE_OUT  = 35'sd1073741824;

    localparam int N_COEF = 7;
    localparam logic signed [P_W-1:0] COEF_Q48 [N_COEF] = '{
        50'sd281474976703081,
        -50'sd46912496042276,
        50'sd2345624675671,
        -50'sd55848122382,
        50'sd775640184,
        -50'sd7046056,
        50'sd44624
    };

    typedef enum logic {
        OP_SIN = 1'b0,
        OP_COS = 1'b1
    } t_opcode;

    typedef struct packed {
        logic signed [XR_W-1:0] x;
        logic        [X2_W-1:0] x2;
        logic signed [P_W-1:0]  p;
    } t_cell_data;

endpackage
`default_nettype wire

FILE: rtl/core/scp_reduce_cell.sv
// Range reduction cell: one correction by 2*pi toward [-pi, pi] per stage.
// Depends on scp_pkg.
`default_nettype none
module scp_reduce_cell (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic signed [scp_pkg::XW-1:0]  i_x,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic signed [scp_pkg::XW-1:0]       o_x
);

    logic                          r_vld;
    logic signed [scp_pkg::XW-1:0] r_x;
    logic signed [scp_pkg::XW-1:0] n_x;
    logic                          adv;

    assign adv     = ~r_vld | i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld;
    assign o_x     = r_x;

    always_comb begin
        if (i_x > scp_pkg::PI_Q) begin
            n_x = i_x - scp_pkg::TWO_PI_Q;
        end else if (i_x < -scp_pkg::PI_Q) begin
            n_x = i_x + scp_pkg::TWO_PI_Q;
        end else begin
            n_x = i_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (adv) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x <= n_x;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/scp_horner_cell.sv
// Horner cell: p = floor(p * x2 / 2^28) + c, split into a partial product stage
// and an accumulate stage. Depends on scp_pkg.
`default_nettype none
module scp_horner_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic signed [scp_pkg::P_W-1:0] i_coef,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire scp_pkg::t_cell_data           i_data,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output scp_pkg::t_cell_data                o_data
);

    localparam int HI_W = scp_pkg::P_W - scp_pkg::PLO;
    localparam int HP_W = HI_W + scp_pkg::X2_W + 1;
    localparam int LP_W = scp_pkg::PLO + scp_pkg::X2_W;
    localparam int SH   = scp_pkg::FRAC_IN - scp_pkg::PLO;

    logic                           r_vld_a;
    logic signed [HP_W-1:0]         r_hi_prod;
    logic        [LP_W-1:0]         r_lo_prod;
    logic signed [scp_pkg::XR_W-1:0] r_x_a;
    logic        [scp_pkg::X2_W-1:0] r_x2_a;
    logic                           r_vld_b;
    scp_pkg::t_cell_data            r_data_b;

    logic                           adv_a;
    logic                           adv_b;
    logic signed [HP_W-1:0]         n_hi_prod;
    logic        [LP_W-1:0]         n_lo_prod;
    logic signed [HP_W-1:0]         sum;
    logic signed [HP_W-1:0]         sum_sh;
    scp_pkg::t_cell_data            n_data_b;

    assign adv_b   = ~r_vld_b | i_ready;
    assign adv_a   = ~r_vld_a | adv_b;
    assign o_ready = adv_a;
    assign o_valid = r_vld_b;
    assign o_data  = r_data_b;

    always_comb begin
        n_hi_prod = HP_W'($signed(i_data.p[scp_pkg::P_W-1:scp_pkg::PLO])
                          * $signed({1'b0, i_data.x2}));
        n_lo_prod = LP_W'(i_data.p[scp_pkg::PLO-1:0] * i_data.x2);
        sum       = r_hi_prod
                  + $signed({{(HP_W-scp_pkg::X2_W){1'b0}},
                             r_lo_prod[LP_W-1:scp_pkg::PLO]});
        sum_sh    = sum >>> SH;
        n_data_b.x  = r_x_a;
        n_data_b.x2 = r_x2_a;
        n_data_b.p  = sum_sh[scp_pkg::P_W-1:0] + i_coef;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (adv_a) begin
                r_vld_a <= i_valid;
            end
            if (adv_b) begin
                r_vld_b <= r_vld_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_hi_prod <= n_hi_prod;
            r_lo_prod <= n_lo_prod;
            r_x_a     <= i_data.x;
            r_x2_a    <= i_data.x2;
        end
        if (adv_b) begin
            r_data_b <= n_data_b;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/scp_output_cell.sv
// Output cell: floor(p * x / 2^46), clamp to +-1 and scale to the output format.
// Holds the result register. Depends on scp_pkg.
`default_nettype none
module scp_output_cell (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire scp_pkg::t_cell_data                 i_data,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [scp_pkg::DATA_WIDTH-1:0]    o_value
);

    localparam int HI_W = scp_pkg::P_W - scp_pkg::PLO;
    localparam int FH_W = HI_W + scp_pkg::XR_W;
    localparam int FL_W = scp_pkg::PLO + 1 + scp_pkg::XR_W;
    localparam int LS_W = FL_W - scp_pkg::PLO;
    localparam int SH   = scp_pkg::OUT_SH - scp_pkg::PLO;

    logic                                   r_vld_a;
    logic signed [FH_W-1:0]                 r_hi_prod;
    logic signed [FL_W-1:0]                 r_lo_prod;
    logic                                   r_vld_b;
    logic signed [scp_pkg::DATA_WIDTH-1:0]  r_value;

    logic                                   adv_a;
    logic                                   adv_b;
    logic signed [FH_W-1:0]                 n_hi_prod;
    logic signed [FL_W-1:0]                 n_lo_prod;
    logic signed [LS_W-1:0]                 lo_sh;
    logic signed [FH_W-1:0]                 sum;
    logic signed [FH_W-1:0]                 sum_sh;
    logic signed [scp_pkg::R_W-1:0]         res_raw;
    logic signed [scp_pkg::R_W-1:0]         res_clamp;
    logic signed [scp_pkg::EXT_W-1:0]       res_ext;
    logic signed [scp_pkg::EXT_W-1:0]       res_scaled;
    logic signed [scp_pkg::DATA_WIDTH-1:0]  n_value;

    assign adv_b   = ~r_vld_b | i_ready;
    assign adv_a   = ~r_vld_a | adv_b;
    assign o_ready = adv_a;
    assign o_valid = r_vld_b;
    assign o_value = r_value;

    always_comb begin
        n_hi_prod = FH_W'($signed(i_data.p[scp_pkg::P_W-1:scp_pkg::PLO]) * i_data.x);
        n_lo_prod = FL_W'($signed({1'b0, i_data.p[scp_pkg::PLO-1:0]}) * i_data.x);
        lo_sh     = r_lo_prod[FL_W-1:scp_pkg::PLO];
        sum       = r_hi_prod + FH_W'(lo_sh);
        sum_sh    = sum >>> SH;
        res_raw   = sum_sh[scp_pkg::R_W-1:0];
        if (res_raw > scp_pkg::ONE_OUT) begin
            res_clamp = scp_pkg::ONE_OUT;
        end else if (res_raw < -scp_pkg::ONE_OUT) begin
            res_clamp = -scp_pkg::ONE_OUT;
        end else begin
            res_clamp = res_raw;
        end
        res_ext    = $signed({{(scp_pkg::EXT_W-scp_pkg::CL_W){res_clamp[scp_pkg::CL_W-1]}},
                              res_clamp[scp_pkg::CL_W-1:0]});
        res_scaled = (res_ext >>> scp_pkg::UP_SH) <<< scp_pkg::DOWN_SH;
        n_value    = res_scaled[scp_pkg::DATA_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (adv_a) begin
                r_vld_a <= i_valid;
            end
            if (adv_b) begin
                r_vld_b <= r_vld_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_hi_prod <= n_hi_prod;
            r_lo_prod <= n_lo_prod;
        end
        if (adv_b) begin
            r_value <= n_value;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/sine_cosine_polynomial_core.sv
// Sine/cosine core: odd seven-coefficient polynomial over a chain of cells.
// Pipeline: 18 registered stages from an accepted request to its result.
// Throughput: one request per cycle; every stage stalls only when full and blocked.
// Stages: front, two 2*pi reduce cells, square, six two-stage Horner cells, output cell.
// Reset: synchronous, active low; clears all stage valid bits, payload is not reset.
// Depends on scp_pkg, scp_reduce_cell, scp_horner_cell, scp_output_cell.
`default_nettype none
module sine_cosine_polynomial_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [scp_pkg::DATA_WIDTH-1:0] i_angle,
    input  wire logic                                i_opcode,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [scp_pkg::DATA_WIDTH-1:0]    o_value
);

    localparam int N_HRN = scp_pkg::N_COEF - 1;
    localparam int SQ_W  = 2 * scp_pkg::XR_W;

    logic                                r_vld_f;
    logic signed [scp_pkg::XW-1:0]       r_x_f;
    logic                                adv_f;
    logic signed [scp_pkg::EXT_W-1:0]    a_ext;
    logic signed [scp_pkg::EXT_W-1:0]    a_scaled;
    logic signed [scp_pkg::A_W-1:0]      a_q28;
    logic signed [scp_pkg::XW-1:0]       a_wide;
    logic signed [scp_pkg::XW-1:0]       n_x_f;

    logic                                vld_r1, rdy_r1, vld_r2, rdy_r2;
    logic signed [scp_pkg::XW-1:0]       x_r1, x_r2;

    logic                                r_vld_s;
    scp_pkg::t_cell_data                 r_data_s;
    logic                                adv_s;
    logic signed [scp_pkg::XR_W-1:0]     x_red;
    logic signed [SQ_W-1:0]              sq;
    scp_pkg::t_cell_data                 n_data_s;

    logic                                vld_h [N_HRN+1];
    logic                                rdy_h [N_HRN+1];
    scp_pkg::t_cell_data                 data_h [N_HRN+1];

    assign adv_f   = ~r_vld_f | rdy_r1;
    assign o_ready = adv_f;

    always_comb begin
        a_ext    = $signed({{(scp_pkg::EXT_W-scp_pkg::DATA_WIDTH){i_angle[scp_pkg::DATA_WIDTH-1]}},
                            i_angle});
        a_scaled = (a_ext >>> scp_pkg::DOWN_SH) <<< scp_pkg::UP_SH;
        a_q28    = a_scaled[scp_pkg::A_W-1:0];
        a_wide   = $signed({{(scp_pkg::XW-scp_pkg::A_W){a_q28[scp_pkg::A_W-1]}}, a_q28});
        if (i_opcode == scp_pkg::OP_COS) begin
            n_x_f = scp_pkg::HALF_PI_Q - a_wide;
        end else begin
            n_x_f = a_wide;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_f <= 1'b0;
        end else if (adv_f) begin
            r_vld_f <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_f) begin
            r_x_f <= n_x_f;
        end
    end

    scp_reduce_cell u_reduce_0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld_f),
        .o_ready (rdy_r1),
        .i_x     (r_x_f),
        .o_valid (vld_r1),
        .i_ready (rdy_r2),
        .o_x     (x_r1)
    );

    scp_reduce_cell u_reduce_1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (vld_r1),
        .o_ready (rdy_r2),
        .i_x     (x_r1),
        .o_valid (vld_r2),
        .i_ready (adv_s),
        .o_x     (x_r2)
    );

    assign adv_s = ~r_vld_s | rdy_h[0];

    always_comb begin
        x_red       = x_r2[scp_pkg::XR_W-1:0];
        sq          = SQ_W'(x_red) * SQ_W'(x_red);
        n_data_s.x  = x_red;
        n_data_s.x2 = sq[scp_pkg::FRAC_IN+scp_pkg::X2_W-1:scp_pkg::FRAC_IN];
        n_data_s.p  = scp_pkg::COEF_Q48[scp_pkg::N_COEF-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_s <= 1'b0;
        end else if (adv_s) begin
            r_vld_s <= vld_r2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_s) begin
            r_data_s <= n_data_s;
        end
    end

    assign vld_h[0]  = r_vld_s;
    assign data_h[0] = r_data_s;

    for (genvar g = 0; g < N_HRN; g++) begin : g_hrn
        scp_horner_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_coef  (scp_pkg::COEF_Q48[N_HRN-1-g]),
            .i_valid (vld_h[g]),
            .o_ready (rdy_h[g]),
            .i_data  (data_h[g]),
            .o_valid (vld_h[g+1]),
            .i_ready (rdy_h[g+1]),
            .o_data  (data_h[g+1])
        );
    end

    scp_output_cell u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (vld_h[N_HRN]),
        .o_ready (rdy_h[N_HRN]),
        .i_data  (data_h[N_HRN]),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_value (o_value)
    );

`ifndef ASSERT_OFF
    a_reduced_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vld_r2 |-> (x_r2 <= scp_pkg::PI_Q) && (x_r2 >= -scp_pkg::PI_Q))
        else $error("reduced angle outside [-pi, pi]");

    a_value_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_value <= $signed(scp_pkg::DATA_WIDTH'(1) <<< (scp_pkg::DATA_WIDTH-2)))
                 && (o_value >= -$signed(scp_pkg::DATA_WIDTH'(1) <<< (scp_pkg::DATA_WIDTH-2))))
        else $error("result beyond plus or minus one");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("request blocked while result register is empty");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/sine_cosine_polynomial_core_tb.sv
// Self-checking bench for sine_cosine_polynomial_core: directed and random angle requests
// under random sender bursts and receiver stalls, each result checked against a bit-exact
// fixed-point polynomial model. Depends on scp_pkg and the core RTL.
module sine_cosine_polynomial_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW       = scp_pkg::DATA_WIDTH;
    localparam int Q_IN     = 28;
    localparam int SHR_IN   = (DW > 32) ? DW - 32 : 0;
    localparam int SHL_IN   = (DW < 32) ? 32 - DW : 0;
    localparam longint Q_HALF_PI = 64'sd421657428;
    localparam longint Q_PI      = 64'sd843314857;
    localparam longint Q_TWO_PI  = 64'sd1686629713;
    localparam longint UNITY_Q30 = 64'sd1073741824;
    localparam int N_RANDOM  = 1650;
    localparam int CYCLE_CAP = 400000;
    localparam int N_TERMS   = 7;
    localparam longint TAYLOR_Q48 [N_TERMS] = '{
        64'sd281474976703081,
        -64'sd46912496042276,
        64'sd2345624675671,
        -64'sd55848122382,
        64'sd775640184,
        -64'sd7046056,
        64'sd44624
    };

    typedef logic signed [DW-1:0] t_word;

    typedef struct {
        t_word            angle;
        scp_pkg::t_opcode op;
        bit               drain;
    } t_angle_req;

    typedef struct {
        t_word            angle;
        scp_pkg::t_opcode op;
        t_word            value;
    } t_sincos_result;

    logic    i_clk    = 1'b0;
    logic    i_rst_n  = 1'b0;
    logic    i_valid  = 1'b0;
    t_word   i_angle  = '0;
    logic    i_opcode = 1'b0;
    logic    i_ready  = 1'b0;
    logic    o_ready;
    logic    o_valid;
    t_word   o_value;

    t_angle_req     angle_queue[$];
    t_sincos_result sincos_in_flight[$];
    logic           req_taken = 1'b0;
    int             bad_count = 0;
    int             cycle_count = 0;
    int             burst_left = 10;
    int             gap_left = 0;
    int             stall_mode = 0;
    int             stall_span = 0;

    sine_cosine_polynomial_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_angle  (i_angle),
        .i_opcode (i_opcode),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_value  (o_value)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint mul_shr_floor(longint a, longint b, int s);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] prod;
        wa = a;
        wb = b;
        prod = wa * wb;
        prod = prod >>> s;
        return longint'(prod);
    endfunction

    function automatic t_word sincos_q30(t_word angle, scp_pkg::t_opcode op);
        longint a;
        longint x;
        longint x2;
        longint p;
        longint r;
        a = longint'(angle);
        a = (a >>> SHR_IN) <<< SHL_IN;
        x = (op == scp_pkg::OP_COS) ? Q_HALF_PI - a : a;
        while (x > Q_PI)
            x -= Q_TWO_PI;
        while (x < -Q_PI)
            x += Q_TWO_PI;
        x2 = (x * x) >>> Q_IN;
        p = TAYLOR_Q48[N_TERMS-1];
        for (int k = N_TERMS - 2; k >= 0; k--)
            p = mul_shr_floor(p, x2, Q_IN) + TAYLOR_Q48[k];
        r = mul_shr_floor(p, x, 46);
        if (r > UNITY_Q30)
            r = UNITY_Q30;
        if (r < -UNITY_Q30)
            r = -UNITY_Q30;
        r = (r >>> SHL_IN) <<< SHR_IN;
        return t_word'(r);
    endfunction

    task automatic flag_bad_value(string what, t_word angle, scp_pkg::t_opcode op,
                                  t_word got, t_word want);
        $display("mismatch: %s angle=%0d op=%s got=%0d want=%0d at cycle %0d",
                 what, angle, op.name(), got, want, cycle_count);
        bad_count++;
    endtask

    task automatic push_request(longint angle_q28, scp_pkg::t_opcode op, bit drain);
        t_angle_req req;
        req.angle = t_word'((angle_q28 <<< SHR_IN) >>> SHL_IN);
        req.op    = op;
        req.drain = drain;
        angle_queue.push_back(req);
    endtask

    function automatic longint random_angle(scp_pkg::t_opcode op);
        longint t;
        longint target;
        int     pick;
        pick = $urandom_range(0, 9);
        if (pick <= 3) begin
            t = longint'($signed({$urandom, $urandom}));
            return t >>> (64 - DW + SHR_IN) <<< 0;
        end
        if (pick <= 5) begin
            case ($urandom_range(0, 3))
                0: target = Q_PI;
                1: target = -Q_PI;
                2: target = Q_HALF_PI;
                default: target = (op == scp_pkg::OP_COS) ? 3 * Q_PI : -Q_HALF_PI;
            endcase
            target += longint'($urandom_range(0, 64)) - 32;
            t = (op == scp_pkg::OP_COS) ? Q_HALF_PI - target : target;
        end else if (pick <= 7) begin
            t = longint'($signed($urandom)) >>> $urandom_range(3, 31);
        end else begin
            t = longint'($urandom_range(0, 1686629714)) - Q_PI;
        end
        return t;
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !req_taken) begin
        end else if (gap_left > 0) begin
            gap_left--;
            i_valid <= 1'b0;
        end else if (angle_queue.size() == 0 ||
                     (angle_queue[0].drain && sincos_in_flight.size() != 0)) begin
            i_valid <= 1'b0;
        end else begin
            t_angle_req req;
            req = angle_queue.pop_front();
            i_valid  <= 1'b1;
            i_angle  <= req.angle;
            i_opcode <= req.op;
            burst_left--;
            if (burst_left <= 0) begin
                gap_left   = $urandom_range(1, 8);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 250)
                                                         : $urandom_range(1, 40);
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(10, 150);
        end
        stall_span--;
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 1) == 1);
            2: i_ready <= ($urandom_range(0, 4) == 0);
            default: i_ready <= ((cycle_count % 5) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_sincos_result res;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (sincos_in_flight.size() == 0) begin
                flag_bad_value("unrequested result", '0, scp_pkg::OP_SIN, o_value, '0);
            end else begin
                res = sincos_in_flight.pop_front();
                if (o_value !== res.value)
                    flag_bad_value("value", res.angle, res.op, o_value, res.value);
            end
        end
        req_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            res.angle = i_angle;
            res.op    = scp_pkg::t_opcode'(i_opcode);
            res.value = sincos_q30(i_angle, scp_pkg::t_opcode'(i_opcode));
            sincos_in_flight.push_back(res);
        end
        if (cycle_count > CYCLE_CAP) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        scp_pkg::t_opcode op;
        push_request(0, scp_pkg::OP_SIN, 1'b0);
        push_request(0, scp_pkg::OP_COS, 1'b0);
        push_request(64'sd2147483647, scp_pkg::OP_SIN, 1'b0);
        push_request(64'sd2147483647, scp_pkg::OP_COS, 1'b0);
        push_request(-64'sd2147483648, scp_pkg::OP_SIN, 1'b0);
        push_request(-64'sd2147483648, scp_pkg::OP_COS, 1'b0);
        push_request(Q_PI, scp_pkg::OP_SIN, 1'b0);
        push_request(-Q_PI, scp_pkg::OP_SIN, 1'b0);
        push_request(Q_PI + 1, scp_pkg::OP_SIN, 1'b0);
        push_request(-Q_PI - 1, scp_pkg::OP_SIN, 1'b0);
        push_request(Q_HALF_PI, scp_pkg::OP_SIN, 1'b0);
        push_request(-Q_HALF_PI, scp_pkg::OP_SIN, 1'b0);
        push_request(Q_HALF_PI - Q_PI, scp_pkg::OP_COS, 1'b0);
        push_request(Q_HALF_PI + Q_PI, scp_pkg::OP_COS, 1'b0);
        push_request(Q_HALF_PI + Q_PI + 1, scp_pkg::OP_COS, 1'b0);
        push_request(Q_HALF_PI - 3 * Q_PI, scp_pkg::OP_COS, 1'b0);
        push_request(Q_HALF_PI - 3 * Q_PI - 1, scp_pkg::OP_COS, 1'b0);
        push_request(-1, scp_pkg::OP_SIN, 1'b0);
        push_request(1, scp_pkg::OP_COS, 1'b0);
        push_request(Q_HALF_PI + 3, scp_pkg::OP_SIN, 1'b0);
        for (int n = 0; n < N_RANDOM; n++) begin
            op = scp_pkg::t_opcode'($urandom_range(0, 1));
            push_request(random_angle(op), op, (n % 400) == 0);
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (angle_queue.size() != 0 || i_valid || sincos_in_flight.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (bad_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
